FILE: hdl/vmt_pkg.sv
// Package for the vertex matrix transform unit: shared constants, opcode and
// register index codes, row reset values and the merge stage control bundle.
// No dependencies.
`default_nettype none

package vmt_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_SHIFT     = 12;
  localparam int N_ROWS         = 4;
  localparam int N_LANES        = 4;
  localparam int CFG_WIDTH      = 64;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic {
    OP_FULL  = 1'b0,
    OP_THREE = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_ZERO  = 2'd0,
    CFG_ROW_ONE   = 2'd1,
    CFG_ROW_TWO   = 2'd2,
    CFG_ROW_THREE = 2'd3
  } cfg_idx_e;

  // identity matrix at the default coefficient width
  localparam logic [N_ROWS-1:0][CFG_WIDTH-1:0] ROW_RESET = {
    64'h1000_0000_0000_0000,
    64'h0000_1000_0000_0000,
    64'h0000_0000_1000_0000,
    64'h0000_0000_0000_1000
  };

  typedef struct packed {
    logic sum_en;
    logic out_en;
  } merge_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/vmt_lane.sv
// One column lane: multiplies one vertex component by the matching
// coefficient of every matrix row and registers the products.
// Depends on vmt_pkg.
`default_nettype none

module vmt_lane #(
  parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = vmt_pkg::COEF_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [DATA_WIDTH-1:0]          operand_i,
  input  logic signed [COEF_WIDTH-1:0]          coef_i [vmt_pkg::N_ROWS],
  output logic signed [DATA_WIDTH+COEF_WIDTH-1:0] prod_o [vmt_pkg::N_ROWS]
);
  import vmt_pkg::*;

  localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;

  logic signed [PROD_W-1:0] prod_d [N_ROWS];
  logic signed [PROD_W-1:0] prod_q [N_ROWS];

  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      prod_d[r] = operand_i * coef_i[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: hdl/vmt_merge.sv
// Merge stage: adds the lane products of each row, then shifts out the
// coefficient fraction and saturates into the output register.
// Depends on vmt_pkg.
`default_nettype none

module vmt_merge #(
  parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = vmt_pkg::COEF_WIDTH_DEF
) (
  input  logic                                    clk_i,
  input  vmt_pkg::merge_ctrl_t                    ctrl_i,
  input  vmt_pkg::op_e                            op_i,
  input  logic signed [DATA_WIDTH+COEF_WIDTH-1:0] prod_i [vmt_pkg::N_LANES][vmt_pkg::N_ROWS],
  output logic signed [DATA_WIDTH-1:0]            res_o  [vmt_pkg::N_ROWS]
);
  import vmt_pkg::*;

  localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + $clog2(N_LANES);
  localparam int HI_W   = SUM_W - DATA_WIDTH + 1;

  localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [SUM_W-1:0]      sum_d   [N_ROWS];
  logic signed [SUM_W-1:0]      sum_q   [N_ROWS];
  logic signed [SUM_W-1:0]      shifted [N_ROWS];
  logic        [HI_W-1:0]       hi_bits [N_ROWS];
  logic signed [DATA_WIDTH-1:0] res_d   [N_ROWS];
  logic signed [DATA_WIDTH-1:0] res_q   [N_ROWS];
  op_e                          op_q;

  // exact four-term sum per row
  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      sum_d[r] = '0;
      for (int l = 0; l < N_LANES; l++) begin
        sum_d[r] = sum_d[r] +
                   {{(SUM_W-PROD_W){prod_i[l][r][PROD_W-1]}}, prod_i[l][r]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
      op_q  <= op_i;
    end
  end

  // floor shift, then clamp to the signed output range
  always_comb begin
    for (int r = 0; r < N_ROWS; r++) begin
      shifted[r] = sum_q[r] >>> FRAC_SHIFT;
      hi_bits[r] = shifted[r][SUM_W-1:DATA_WIDTH-1];
      if ((&hi_bits[r]) || !(|hi_bits[r])) begin
        res_d[r] = shifted[r][DATA_WIDTH-1:0];
      end else if (shifted[r][SUM_W-1]) begin
        res_d[r] = SAT_MIN;
      end else begin
        res_d[r] = SAT_MAX;
      end
    end
    // three-by-three transform drops the last component
    if (op_q == OP_THREE) begin
      res_d[N_ROWS-1] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: hdl/vertex_matrix_transform_unit.sv
// Vertex matrix transform unit, top level: row registers, four column lanes,
// merge stage and the pipeline handshake.
// Depends on vmt_pkg, vmt_lane and vmt_merge.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one vertex word: opcode
//    plus signed Q16.16 x, y, z, w. Output channel (out_valid_o / out_ready_i)
//    returns one transformed vertex word per input word, in order.
//  - Opcode full multiplies by the whole 4x4 matrix; opcode three uses the
//    upper-left 3x3, ignores w and returns out_w as zero.
//  - Each row register holds four signed Q4.12 coefficients, x in the low
//    slot. Write them through cfg_we_i / cfg_idx_i / cfg_data_i while the
//    unit is idle; a write takes effect at the clock edge.
//  - Three register stages: lane multiply, row sum, shift and saturate.
//    out_valid_o rises once an accepted word reaches the output register.
//    Throughput is one word per clock while the receiver does not stall, set
//    by the three-stage pipeline with a multiplier per coefficient.
//  - Reset clears all pipeline valids and loads the identity matrix.
//  - When the receiver stalls, each stage holds its word and bubbles are
//    squeezed out; in_ready_o drops only once all three stages are full.
`default_nettype none

module vertex_matrix_transform_unit #(
  parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = vmt_pkg::COEF_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [vmt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [vmt_pkg::CFG_WIDTH-1:0]    cfg_data_i,
  // input vertex channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             opcode_i,
  input  logic signed [DATA_WIDTH-1:0]     in_x_i,
  input  logic signed [DATA_WIDTH-1:0]     in_y_i,
  input  logic signed [DATA_WIDTH-1:0]     in_z_i,
  input  logic signed [DATA_WIDTH-1:0]     in_w_i,
  // output vertex channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [DATA_WIDTH-1:0]     out_x_o,
  output logic signed [DATA_WIDTH-1:0]     out_y_o,
  output logic signed [DATA_WIDTH-1:0]     out_z_o,
  output logic signed [DATA_WIDTH-1:0]     out_w_o
);
  import vmt_pkg::*;

  localparam int PROD_W = DATA_WIDTH + COEF_WIDTH;

  // Matrix row registers
  logic [N_ROWS-1:0][CFG_WIDTH-1:0] row_q, row_d;

  always_comb begin
    row_d = row_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_ZERO:  row_d[0] = cfg_data_i;
        CFG_ROW_ONE:   row_d[1] = cfg_data_i;
        CFG_ROW_TWO:   row_d[2] = cfg_data_i;
        CFG_ROW_THREE: row_d[3] = cfg_data_i;
        default:       row_d    = row_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= ROW_RESET;
    end else begin
      row_q <= row_d;
    end
  end

  // Pipeline control: a stage takes a word when it is empty or its word
  // moves on in the same cycle.
  logic v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic take1, take2, take3;
  logic in_accept;

  assign take3     = !v3_q || out_ready_i;
  assign take2     = !v2_q || take3;
  assign take1     = !v1_q || take2;
  assign in_accept = in_valid_i && take1;

  assign v1_d = take1 ? in_valid_i : v1_q;
  assign v2_d = take2 ? v1_q       : v2_q;
  assign v3_d = take3 ? v2_q       : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign in_ready_o  = take1;
  assign out_valid_o = v3_q;

  // Opcode travels with the products into the merge stage
  op_e op1_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op1_q <= op_e'(opcode_i);
    end
  end

  // Lane operands: w drops out of the three-by-three transform
  logic signed [DATA_WIDTH-1:0] lane_opnd [N_LANES];
  logic signed [COEF_WIDTH-1:0] lane_coef [N_LANES][N_ROWS];
  logic signed [PROD_W-1:0]     lane_prod [N_LANES][N_ROWS];

  always_comb begin
    lane_opnd[0] = in_x_i;
    lane_opnd[1] = in_y_i;
    lane_opnd[2] = in_z_i;
    lane_opnd[3] = (op_e'(opcode_i) == OP_THREE) ? '0 : in_w_i;
    for (int l = 0; l < N_LANES; l++) begin
      for (int r = 0; r < N_ROWS; r++) begin
        lane_coef[l][r] = row_q[r][l*COEF_WIDTH +: COEF_WIDTH];
      end
    end
  end

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    vmt_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (in_accept),
      .operand_i (lane_opnd[l]),
      .coef_i    (lane_coef[l]),
      .prod_o    (lane_prod[l])
    );
  end

  // Merge stage: row sums, then shift and clamp into the output register
  merge_ctrl_t                  merge_ctrl;
  logic signed [DATA_WIDTH-1:0] merge_res [N_ROWS];

  assign merge_ctrl.sum_en = take2 && v1_q;
  assign merge_ctrl.out_en = take3 && v2_q;

  vmt_merge #(
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_merge (
    .clk_i  (clk_i),
    .ctrl_i (merge_ctrl),
    .op_i   (op1_q),
    .prod_i (lane_prod),
    .res_o  (merge_res)
  );

  assign out_x_o = merge_res[0];
  assign out_y_o = merge_res[1];
  assign out_z_o = merge_res[2];
  assign out_w_o = merge_res[3];

endmodule

`default_nettype wire

FILE: hdl/vmt_checker.sv
// Port-level checker for the vertex matrix transform unit, bound to the top
// level. Depends on vmt_pkg and vertex_matrix_transform_unit.
`default_nettype none

module vmt_assert_checker #(
  parameter int DATA_WIDTH = vmt_pkg::DATA_WIDTH_DEF
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_ready_o,
  input wire                  opcode_i,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input wire [DATA_WIDTH-1:0] out_x_o,
  input wire [DATA_WIDTH-1:0] out_w_o
);
  import vmt_pkg::*;

  // stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o))
    else $error("output word dropped or changed while stalled");

  // input back-pressure only when the output is stalled
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled output");

  // free-flowing word shows up once it has passed the three register stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_ready_i) ##1 out_ready_i ##1 out_ready_i
    |=> out_valid_o)
    else $error("word did not emerge after three cycles");

  // three-by-three transform returns w as zero
  a_three_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && out_ready_i && opcode_i == OP_THREE)
    ##1 out_ready_i ##1 out_ready_i
    |=> out_w_o == '0)
    else $error("three-by-three transform gave nonzero w");

endmodule

bind vertex_matrix_transform_unit vmt_assert_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_vmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .opcode_i    (opcode_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_x_o     (out_x_o),
  .out_w_o     (out_w_o)
);

`default_nettype wire
